@@ src/ima_pkg.sv @@
// Shared types, constants and step table for the IMA ADPCM decoder.
`timescale 1ns / 1ps

package ima_pkg;

   localparam int CODE_W  = 4;
   localparam int INDEX_W = 7;
   localparam int PCM_W   = 16;
   localparam int STEP_W  = 15;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 16;

   localparam logic [INDEX_W-1:0] MAX_STEP_INDEX = 7'd88;
   localparam logic signed [PCM_W-1:0] PCM_MAX = 16'sh7fff;
   localparam logic signed [PCM_W-1:0] PCM_MIN = -16'sh8000;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_START_PREDICTOR  = 1'b0,
      CSR_START_STEP_INDEX = 1'b1
   } csr_index_type;

   localparam logic [STEP_W-1:0] STEP_SIZE_LUT [0:88] = '{
      15'd7,     15'd8,     15'd9,     15'd10,    15'd11,    15'd12,    15'd13,
      15'd14,    15'd16,    15'd17,    15'd19,    15'd21,    15'd23,    15'd25,
      15'd28,    15'd31,    15'd34,    15'd37,    15'd41,    15'd45,    15'd50,
      15'd55,    15'd60,    15'd66,    15'd73,    15'd80,    15'd88,    15'd97,
      15'd107,   15'd118,   15'd130,   15'd143,   15'd157,   15'd173,   15'd190,
      15'd209,   15'd230,   15'd253,   15'd279,   15'd307,   15'd337,   15'd371,
      15'd408,   15'd449,   15'd494,   15'd544,   15'd598,   15'd658,   15'd724,
      15'd796,   15'd876,   15'd963,   15'd1060,  15'd1166,  15'd1282,  15'd1411,
      15'd1552,  15'd1707,  15'd1878,  15'd2066,  15'd2272,  15'd2499,  15'd2749,
      15'd3024,  15'd3327,  15'd3660,  15'd4026,  15'd4428,  15'd4871,  15'd5358,
      15'd5894,  15'd6484,  15'd7132,  15'd7845,  15'd8630,  15'd9493,  15'd10442,
      15'd11487, 15'd12635, 15'd13899, 15'd15289, 15'd16818, 15'd18500, 15'd20350,
      15'd22385, 15'd24623, 15'd27086, 15'd29794, 15'd32767
   };

   // index adjustment per magnitude
   localparam logic signed [4:0] INDEX_MOVE [0:7] = '{
      -5'sd1, -5'sd1, -5'sd1, -5'sd1, 5'sd2, 5'sd4, 5'sd6, 5'sd8
   };

   typedef struct packed {
      logic signed [PCM_W-1:0] predictor;
      logic [INDEX_W-1:0]      step_index;
   } dec_state_type;

   function automatic logic [STEP_W-1:0] step_lookup(input logic [INDEX_W-1:0] idx);
      logic [INDEX_W-1:0] safe;
      safe = (idx > MAX_STEP_INDEX) ? MAX_STEP_INDEX : idx;
      return STEP_SIZE_LUT[safe];
   endfunction

endpackage

@@ src/ima_req_if.sv @@
// Input channel: one ADPCM code word per handshake.
`timescale 1ns / 1ps

interface ima_req_if;
   logic       valid;
   logic       ready;
   logic [3:0] adpcm_code;
   logic       restart;
   logic       end_of_block;

   modport source (output valid, adpcm_code, restart, end_of_block, input ready);
   modport sink   (input valid, adpcm_code, restart, end_of_block, output ready);
endinterface

@@ src/ima_rsp_if.sv @@
// Result channel: one decoded PCM sample word per handshake.
`timescale 1ns / 1ps

interface ima_rsp_if;
   logic              valid;
   logic              ready;
   logic signed [15:0] pcm_sample;
   logic [6:0]        next_step_index;
   logic              last_of_block;

   modport source (output valid, pcm_sample, next_step_index, last_of_block, input ready);
   modport sink   (input valid, pcm_sample, next_step_index, last_of_block, output ready);
endinterface

@@ src/ima_decode.sv @@
// Combinational decode of one code: step lookup, difference, saturation, index update.
`timescale 1ns / 1ps

module ima_decode (
   input  ima_pkg::dec_state_type         cur,
   input  logic [ima_pkg::CODE_W-1:0]     code,
   output ima_pkg::dec_state_type         nxt
);
   import ima_pkg::*;

   localparam logic signed [PCM_W+1:0] SUM_MAX = 18'sd32767;
   localparam logic signed [PCM_W+1:0] SUM_MIN = -18'sd32768;

   logic [2:0]               mag;
   logic [STEP_W-1:0]        step;
   logic [STEP_W+2:0]        prod;
   logic [PCM_W-1:0]         diff;
   logic signed [PCM_W+1:0]  pred_ext;
   logic signed [PCM_W+1:0]  diff_ext;
   logic signed [PCM_W+1:0]  sum;
   logic signed [INDEX_W+1:0] idx_sum;

   always_comb begin
      mag  = code[2:0];
      step = step_lookup(cur.step_index);
      prod = 18'(step) * 18'(mag);
      diff = 16'(prod >> 2) + 16'(step >> 3);

      pred_ext = {{2{cur.predictor[PCM_W-1]}}, cur.predictor};
      diff_ext = $signed({2'b00, diff});
      sum = code[3] ? (pred_ext - diff_ext) : (pred_ext + diff_ext);

      if (sum > SUM_MAX) begin
         nxt.predictor = PCM_MAX;
      end else if (sum < SUM_MIN) begin
         nxt.predictor = PCM_MIN;
      end else begin
         nxt.predictor = sum[PCM_W-1:0];
      end

      idx_sum = $signed({2'b00, cur.step_index}) + 9'(INDEX_MOVE[mag]);
      if (idx_sum < 0) begin
         nxt.step_index = '0;
      end else if (idx_sum > $signed({2'b00, MAX_STEP_INDEX})) begin
         nxt.step_index = MAX_STEP_INDEX;
      end else begin
         nxt.step_index = idx_sum[INDEX_W-1:0];
      end
   end

endmodule

@@ src/ima_adpcm_decoder.sv @@
// IMA ADPCM 4-bit decoder top level: input stage, decode state and result register.
// Data path: an accepted code word is held in the input register, then the decoded word
// is loaded into the result register when the result stage can advance.
// Throughput: one code word per cycle unless results stall; the predictor/index recurrence
// closes in the single decode stage between the input register and the result register.
// Reset (synchronous, active high) clears predictor, step index, start registers and valids.
`timescale 1ns / 1ps

module ima_adpcm_decoder (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_we,
   input  logic [ima_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [ima_pkg::CSR_DATA_W-1:0]    csr_wdata,
   ima_req_if.sink                           req_chan,
   ima_rsp_if.source                         rsp_chan
);
   import ima_pkg::*;

   // configuration
   logic signed [PCM_W-1:0] start_pred_ff;
   logic [INDEX_W-1:0]      start_idx_ff;

   // decoder state
   dec_state_type state_ff;
   dec_state_type state_in;
   dec_state_type cur;

   // input stage
   logic                s1_vld_ff;
   logic [CODE_W-1:0]   s1_code_ff;
   logic                s1_restart_ff;
   logic                s1_eob_ff;

   // result stage
   logic                out_vld_ff;
   logic signed [PCM_W-1:0] out_pcm_ff;
   logic [INDEX_W-1:0]  out_idx_ff;
   logic                out_eob_ff;

   logic out_adv;
   logic s1_fire;
   logic req_fire;

   assign out_adv  = !out_vld_ff || rsp_chan.ready;
   assign s1_fire  = s1_vld_ff && out_adv;
   assign req_chan.ready = !s1_vld_ff || out_adv;
   assign req_fire = req_chan.valid && req_chan.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         start_pred_ff <= '0;
         start_idx_ff  <= '0;
      end else if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_START_PREDICTOR:  start_pred_ff <= csr_wdata[PCM_W-1:0];
            CSR_START_STEP_INDEX: start_idx_ff  <= csr_wdata[INDEX_W-1:0];
            default: ;
         endcase
      end
   end

   // restart reloads state ahead of decode; start index saturates to the table end
   always_comb begin
      if (s1_restart_ff) begin
         cur.predictor  = start_pred_ff;
         cur.step_index = (start_idx_ff > MAX_STEP_INDEX) ? MAX_STEP_INDEX : start_idx_ff;
      end else begin
         cur = state_ff;
      end
   end

   ima_decode u_decode (
      .cur  (cur),
      .code (s1_code_ff),
      .nxt  (state_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= '0;
         s1_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         if (s1_fire) begin
            state_ff <= state_in;
         end
         if (req_chan.ready) begin
            s1_vld_ff <= req_chan.valid;
         end
         if (out_adv) begin
            out_vld_ff <= s1_vld_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_code_ff    <= req_chan.adpcm_code;
         s1_restart_ff <= req_chan.restart;
         s1_eob_ff     <= req_chan.end_of_block;
      end
      if (s1_fire) begin
         out_pcm_ff <= state_in.predictor;
         out_idx_ff <= state_in.step_index;
         out_eob_ff <= s1_eob_ff;
      end
   end

   assign rsp_chan.valid           = out_vld_ff;
   assign rsp_chan.pcm_sample      = out_pcm_ff;
   assign rsp_chan.next_step_index = out_idx_ff;
   assign rsp_chan.last_of_block   = out_eob_ff;

   a_reset_clears_out: assert property (@(posedge clock) reset |=> !rsp_chan.valid)
      else $error("result valid after reset");

   a_index_range: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> (rsp_chan.next_step_index <= MAX_STEP_INDEX))
      else $error("step index out of range");

   a_state_tracks_out: assert property (@(posedge clock) disable iff (reset)
      s1_fire |=> (state_ff.predictor == rsp_chan.pcm_sample
                   && state_ff.step_index == rsp_chan.next_step_index))
      else $error("decoder state differs from emitted word");

   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      (s1_vld_ff && !out_adv) |-> !req_chan.ready)
      else $error("input stage overrun");

endmodule
